// File: sv/msh_pkg.sv
package msh_pkg;

    // field widths
    localparam int RAW_W    = 13;
    localparam int GAIN_W   = 11;
    localparam int SCALED_W = 24;
    localparam int DECL_W   = 16;
    localparam int HEAD_W   = 16;
    localparam int DEG_W    = 15;

    // cordic sizing
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NRUN   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int IDX_W  = $clog2(ATAN_ENTRIES);
    // axes carry 24 fraction bits so shift truncation lands on the same bits as the q24 angle
    localparam int FRAC_W = 24;
    localparam int XY_W   = 25 + FRAC_W;
    localparam int Z_W    = 28;
    localparam int ANG_W  = Z_W - 11;

    // angle constants in q13, half pi in q24
    localparam int PI_Q13     = 25736;
    localparam int TWO_PI_Q13 = 51472;
    localparam int HALF_PI_Q24x2 = 26353590;

    // degree conversion: (h*23040 + 25736) / 51472 == (h*1440 + 1608) / 3217
    localparam int DEG_SCALE  = 1440;
    localparam int DEG_BIAS   = 1608;
    localparam int DEG_DIV    = 3217;
    localparam int DEG_N_W    = 27;
    localparam int DEG_SHIFT  = 40;
    localparam int DEG_MUL_W  = 29;
    localparam longint unsigned DEG_MUL_L =
        ((64'd1 << DEG_SHIFT) + 64'(DEG_DIV) - 64'd1) / 64'(DEG_DIV);
    localparam logic [DEG_MUL_W-1:0] DEG_MUL = DEG_MUL_W'(DEG_MUL_L);
    localparam int DEG_PROD_W = DEG_N_W + DEG_MUL_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 1'd1;

    localparam logic [2:0]        GAIN_SELECT_RST = 3'd1;
    localparam logic [DECL_W-1:0] DECLINATION_RST = 16'd1797;

    typedef struct packed {
        logic signed [SCALED_W-1:0] sx;
        logic signed [SCALED_W-1:0] sy;
        logic signed [SCALED_W-1:0] sz;
    } scaled_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
        scaled_t                s;
    } cordic_t;

    // q8 gain per field range code
    function automatic logic [GAIN_W-1:0] gain_q8(input logic [2:0] code);
        logic [GAIN_W-1:0] g;
        unique case (code)
            3'd0: g = 11'd187;
            3'd1: g = 11'd236;
            3'd2: g = 11'd312;
            3'd3: g = 11'd389;
            3'd4: g = 11'd581;
            3'd5: g = 11'd655;
            3'd6: g = 11'd776;
            3'd7: g = 11'd1114;
        endcase
        return g;
    endfunction

    // q24 arctangent of 2^-i
    function automatic logic signed [Z_W-1:0] atan_q24(input logic [IDX_W-1:0] i);
        logic signed [Z_W-1:0] a;
        unique case (i)
            5'd0:  a = 28'sd13176795;
            5'd1:  a = 28'sd7778716;
            5'd2:  a = 28'sd4110060;
            5'd3:  a = 28'sd2086331;
            5'd4:  a = 28'sd1047214;
            5'd5:  a = 28'sd524117;
            5'd6:  a = 28'sd262123;
            5'd7:  a = 28'sd131069;
            5'd8:  a = 28'sd65536;
            5'd9:  a = 28'sd32768;
            5'd10: a = 28'sd16384;
            5'd11: a = 28'sd8192;
            5'd12: a = 28'sd4096;
            5'd13: a = 28'sd2048;
            5'd14: a = 28'sd1024;
            5'd15: a = 28'sd512;
            5'd16: a = 28'sd256;
            5'd17: a = 28'sd128;
            5'd18: a = 28'sd64;
            5'd19: a = 28'sd32;
            5'd20: a = 28'sd16;
            5'd21: a = 28'sd8;
            5'd22: a = 28'sd4;
            5'd23: a = 28'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: sv/msh_front.sv
module msh_front
    import msh_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [RAW_W-1:0]    raw_x,
    input  logic signed [RAW_W-1:0]    raw_y,
    input  logic signed [RAW_W-1:0]    raw_z,
    input  logic [2:0]                 gain_select,
    output logic                       out_valid,
    output cordic_t                    out_word
);

    logic                       v1_reg;
    scaled_t                    s1_reg;
    scaled_t                    s1_next;
    logic                       v2_reg;
    cordic_t                    w2_reg;
    cordic_t                    w2_next;
    logic signed [SCALED_W-1:0] gain_s;
    logic signed [XY_W-1:0]     xe;
    logic signed [XY_W-1:0]     ye;

    // gain times raw axis
    assign gain_s     = SCALED_W'($signed({1'b0, gain_q8(gain_select)}));
    assign s1_next.sx = SCALED_W'(raw_x) * gain_s;
    assign s1_next.sy = SCALED_W'(raw_y) * gain_s;
    assign s1_next.sz = SCALED_W'(raw_z) * gain_s;

    // turn left half plane vectors into the right half plane
    assign xe = XY_W'(s1_reg.sx) <<< FRAC_W;
    assign ye = XY_W'(s1_reg.sy) <<< FRAC_W;

    always_comb
    begin
        w2_next.s    = s1_reg;
        w2_next.zero = (s1_reg.sx == '0) && (s1_reg.sy == '0);
        w2_next.x    = xe;
        w2_next.y    = ye;
        w2_next.z    = '0;
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                w2_next.x = ye;
                w2_next.y = -xe;
                w2_next.z = Z_W'(HALF_PI_Q24x2);
            end
            else
            begin
                w2_next.x = -ye;
                w2_next.y = xe;
                w2_next.z = Z_W'(-HALF_PI_Q24x2);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        w2_reg <= w2_next;
    end

    assign out_valid = v2_reg;
    assign out_word  = w2_reg;

endmodule

// File: sv/msh_cell.sv
module msh_cell
    import msh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] stage_idx,
    input  logic             in_valid,
    input  cordic_t          in_word,
    output logic             out_valid,
    output cordic_t          out_word
);

    logic                   valid_reg;
    cordic_t                word_reg;
    cordic_t                word_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  step_angle;

    // one vectoring micro-rotation toward y = 0
    assign xs         = in_word.x >>> stage_idx;
    assign ys         = in_word.y >>> stage_idx;
    assign step_angle = atan_q24(stage_idx);

    always_comb
    begin
        word_next = in_word;
        if (!in_word.y[XY_W-1])
        begin
            word_next.x = in_word.x + ys;
            word_next.y = in_word.y - xs;
            word_next.z = in_word.z + step_angle;
        end
        else
        begin
            word_next.x = in_word.x - ys;
            word_next.y = in_word.y + xs;
            word_next.z = in_word.z - step_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: sv/msh_back.sv
module msh_back
    import msh_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  cordic_t                    in_word,
    input  logic signed [DECL_W-1:0]   declination,
    output logic                       done,
    output logic signed [SCALED_W-1:0] scaled_x,
    output logic signed [SCALED_W-1:0] scaled_y,
    output logic signed [SCALED_W-1:0] scaled_z,
    output logic [HEAD_W-1:0]          heading_q13,
    output logic [DEG_W-1:0]           heading_deg
);

    logic                        vr_reg;
    logic                        vw_reg;
    logic                        vd_reg;
    logic                        vo_reg;
    scaled_t                     sr_reg;
    scaled_t                     sw_reg;
    scaled_t                     sd_reg;
    scaled_t                     so_reg;
    logic signed [HEAD_W-1:0]    ang_reg;
    logic signed [HEAD_W-1:0]    ang_next;
    logic [HEAD_W-1:0]           hw_reg;
    logic [HEAD_W-1:0]           hw_next;
    logic [HEAD_W-1:0]           hd_reg;
    logic [HEAD_W-1:0]           ho_reg;
    logic [DEG_N_W-1:0]          n_reg;
    logic [DEG_N_W-1:0]          n_next;
    logic [DEG_W-1:0]            deg_reg;
    logic [DEG_PROD_W-1:0]       prod;
    logic signed [Z_W-1:0]       z_bias;
    logic signed [ANG_W-1:0]     z_q13;
    logic signed [HEAD_W+1:0]    h_sum;

    // round q24 to q13 half up, clamp to +-pi, zero vector gives zero
    assign z_bias = in_word.z + Z_W'(1024);
    assign z_q13  = z_bias[Z_W-1:11];

    always_comb
    begin
        priority if (in_word.zero)
            ang_next = '0;
        else if (z_q13 > PI_Q13)
            ang_next = HEAD_W'(PI_Q13);
        else if (z_q13 < -PI_Q13)
            ang_next = HEAD_W'(-PI_Q13);
        else
            ang_next = HEAD_W'(z_q13);
    end

    // add declination and wrap into 0..2pi, 2pi kept
    assign h_sum = (HEAD_W+2)'(ang_reg) + (HEAD_W+2)'(declination);

    always_comb
    begin
        priority if (h_sum < -TWO_PI_Q13)
            hw_next = HEAD_W'(h_sum + 2 * TWO_PI_Q13);
        else if (h_sum < 0)
            hw_next = HEAD_W'(h_sum + TWO_PI_Q13);
        else if (h_sum > TWO_PI_Q13)
            hw_next = HEAD_W'(h_sum - TWO_PI_Q13);
        else
            hw_next = HEAD_W'(h_sum);
    end

    // degree numerator, then divide by reciprocal multiply (exact over the range)
    assign n_next = DEG_N_W'(hw_reg) * DEG_N_W'(DEG_SCALE) + DEG_N_W'(DEG_BIAS);
    assign prod   = DEG_PROD_W'(n_reg) * DEG_PROD_W'(DEG_MUL);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
            vw_reg <= 1'b0;
            vd_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            vr_reg <= in_valid;
            vw_reg <= vr_reg;
            vd_reg <= vw_reg;
            vo_reg <= vd_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        sr_reg  <= in_word.s;
        ang_reg <= ang_next;
        sw_reg  <= sr_reg;
        hw_reg  <= hw_next;
        sd_reg  <= sw_reg;
        hd_reg  <= hw_reg;
        n_reg   <= n_next;
        so_reg  <= sd_reg;
        ho_reg  <= hd_reg;
        deg_reg <= prod[DEG_SHIFT +: DEG_W];
    end

    assign done        = vo_reg;
    assign scaled_x    = so_reg.sx;
    assign scaled_y    = so_reg.sy;
    assign scaled_z    = so_reg.sz;
    assign heading_q13 = ho_reg;
    assign heading_deg = deg_reg;

endmodule

// File: sv/magnetometer_scale_and_heading.sv
// Scales a three-axis magnetometer word by the gain of the selected field range and
// returns the compass heading, atan2(y, x) plus declination wrapped into 0..2pi, in
// q13 radians and in 1/64 degree. The block is a straight pipeline: a gain multiply
// stage, a half-plane pre-rotation stage, one CORDIC cell per stage (CORDIC_STAGES,
// at most 24) and four stages for rounding, wrap and degree conversion. It takes one
// word on every clock (busy stays low). Each result is on the outputs with done high
// for one cycle, registered through the front stages, the cells and the back stages.
// The receiver must take the result in that cycle; there is no hold-off. Write
// gain_select and declination only while no word is in flight.
module magnetometer_scale_and_heading
    import msh_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [RAW_W-1:0]    raw_x,
    input  logic signed [RAW_W-1:0]    raw_y,
    input  logic signed [RAW_W-1:0]    raw_z,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DECL_W-1:0]          cfg_data,
    output logic                       done,
    output logic signed [SCALED_W-1:0] scaled_x,
    output logic signed [SCALED_W-1:0] scaled_y,
    output logic signed [SCALED_W-1:0] scaled_z,
    output logic [HEAD_W-1:0]          heading_q13,
    output logic [DEG_W-1:0]           heading_deg
);

    logic [2:0]        gain_select_reg;
    logic [DECL_W-1:0] declination_reg;
    logic              accept;
    logic              chain_v [0:NRUN];
    cordic_t           chain_w [0:NRUN];

    // fully pipelined, never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_select_reg <= GAIN_SELECT_RST;
            declination_reg <= DECLINATION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_SELECT: gain_select_reg <= cfg_data[2:0];
                REG_DECLINATION: declination_reg <= cfg_data;
            endcase
        end
    end

    // gain and pre-rotation
    msh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .raw_x       (raw_x),
        .raw_y       (raw_y),
        .raw_z       (raw_z),
        .gain_select (gain_select_reg),
        .out_valid   (chain_v[0]),
        .out_word    (chain_w[0])
    );

    // row of cordic cells
    for (genvar i = 0; i < NRUN; i++)
    begin : g_cell
        msh_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (IDX_W'(i)),
            .in_valid  (chain_v[i]),
            .in_word   (chain_w[i]),
            .out_valid (chain_v[i+1]),
            .out_word  (chain_w[i+1])
        );
    end

    // rounding, declination, wrap and degrees
    msh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (chain_v[NRUN]),
        .in_word     (chain_w[NRUN]),
        .declination ($signed(declination_reg)),
        .done        (done),
        .scaled_x    (scaled_x),
        .scaled_y    (scaled_y),
        .scaled_z    (scaled_z),
        .heading_q13 (heading_q13),
        .heading_deg (heading_deg)
    );

endmodule

// File: sv/msh_checker.sv
module msh_checker
    import msh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              done,
    input  logic [HEAD_W-1:0] heading_q13,
    input  logic [DEG_W-1:0]  heading_deg
);

    localparam int LAT = NRUN + 6;

    // every accepted word comes out after the fixed latency
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted word did not produce a result");

    // no result without a word taken earlier
    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an accepted word");

    // heading stays inside 0..2pi
    a_rad_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (heading_q13 <= HEAD_W'(TWO_PI_Q13)))
        else $error("heading radians out of range");

    // full turn maps to full degrees
    a_full_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (done && heading_q13 == HEAD_W'(TWO_PI_Q13)) |->
            (heading_deg == DEG_W'(23040)))
        else $error("2pi heading not 360 degrees");

    // zero heading maps to zero degrees
    a_zero_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (done && heading_q13 == '0) |-> (heading_deg == '0))
        else $error("zero heading not zero degrees");

endmodule

bind magnetometer_scale_and_heading msh_checker u_msh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .heading_q13 (heading_q13),
    .heading_deg (heading_deg)
);
